FILE: rtl/core/assert_macros.svh
// Assertion helpers for the isoline block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle, consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent and consequent in the same cycle.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/iccec_pkg.sv
`timescale 1ns / 1ps
package iccec_pkg;
  localparam int SMP_W   = 16;
  localparam int FRAC_W  = 8;
  localparam int CRD_W   = 10;
  localparam int PT_W    = CRD_W + FRAC_W;
  localparam int T_W     = FRAC_W + 1;
  localparam int DEPTH   = T_W + 1;
  localparam int NLANE   = 4;
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam logic [PT_W:0] XLIM = (PT_W + 1)'((MAX_COLS - 1) << FRAC_W);
  localparam logic [PT_W:0] YLIM = (PT_W + 1)'((MAX_ROWS - 1) << FRAC_W);

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic [PT_W-1:0]         pt_t;
  typedef logic [1:0]              edge_t;

  localparam edge_t EDGE_BOTTOM = 2'd0;
  localparam edge_t EDGE_RIGHT  = 2'd1;
  localparam edge_t EDGE_TOP    = 2'd2;
  localparam edge_t EDGE_LEFT   = 2'd3;

  typedef struct packed {
    logic           crossed;
    logic [T_W-1:0] t;
  } lane_res_t;

  typedef struct packed {
    logic load;
    logic load_ok;
  } mrg_ctl_t;
endpackage

FILE: rtl/core/isoline_cell_edge_crossings.sv
`timescale 1ns / 1ps
// Channel  | ports                                         | moves
// in       | in_valid, in_stall, in_corner_*, in_cell_*    | one grid cell a transfer
// out      | out_valid, out_stall, out_point_*, out_edge_id, out_last_point | one point
// cfg      | cfg_wr_en, cfg_wr_data                        | contour level write
//
// Pipeline: an accepted cell reaches the merge stage through an entry
// register and one divider stage per quotient bit, 9 bits.
// Output: a cell sends its points, 2 or 4, one after another, while a cell with
// no crossings sends none; the output port moves one point a cycle unless
// out_stall holds it.
// Reset: synchronous, active low; clears valid bits, pending points and the level.
// Stalls: out_stall holds the current point; the pipeline freezes only when its
// tail holds a cell that the merge stage cannot yet take.
module isoline_cell_edge_crossings import iccec_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  smp_t             cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  smp_t             in_corner_low_left,
  input  smp_t             in_corner_low_right,
  input  smp_t             in_corner_up_right,
  input  smp_t             in_corner_up_left,
  input  logic [CRD_W-1:0] in_cell_column,
  input  logic [CRD_W-1:0] in_cell_row,
  output logic             out_valid,
  input  logic             out_stall,
  output pt_t              out_point_x,
  output pt_t              out_point_y,
  output edge_t            out_edge_id,
  output logic             out_last_point
);
`include "assert_macros.svh"

  smp_t             level_r;
  logic [DEPTH-1:0] vld_r;
  logic [CRD_W-1:0] col_r [DEPTH];
  logic [CRD_W-1:0] row_r [DEPTH];
  logic             adv;
  mrg_ctl_t         mctl;
  lane_res_t        lres [NLANE];
  smp_t             za [NLANE];
  smp_t             zb [NLANE];

  // the whole pipeline steps together unless its tail is blocked
  assign adv      = ~vld_r[DEPTH-1] | mctl.load_ok;
  assign in_stall = ~adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (cfg_wr_en) begin
      level_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_r[0] <= in_cell_column;
      row_r[0] <= in_cell_row;
      for (int k = 1; k < DEPTH; k++) begin
        col_r[k] <= col_r[k-1];
        row_r[k] <= row_r[k-1];
      end
    end
  end

  // edge start and end corners: bottom, right, top, left
  assign za[EDGE_BOTTOM] = in_corner_low_left;
  assign zb[EDGE_BOTTOM] = in_corner_low_right;
  assign za[EDGE_RIGHT]  = in_corner_low_right;
  assign zb[EDGE_RIGHT]  = in_corner_up_right;
  assign za[EDGE_TOP]    = in_corner_up_right;
  assign zb[EDGE_TOP]    = in_corner_up_left;
  assign za[EDGE_LEFT]   = in_corner_up_left;
  assign zb[EDGE_LEFT]   = in_corner_low_left;

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    iccec_lane u_lane (
      .clk (clk),
      .adv (adv),
      .a   (za[i]),
      .b   (zb[i]),
      .lev (level_r),
      .res (lres[i])
    );
  end

  iccec_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .tail_valid     (vld_r[DEPTH-1]),
    .lres           (lres),
    .col            (col_r[DEPTH-1]),
    .row            (row_r[DEPTH-1]),
    .ctl            (mctl),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_edge_id    (out_edge_id),
    .out_last_point (out_last_point)
  );

  `ASSERT_NEXT(a_tail_held, vld_r[DEPTH-1] && !adv, vld_r[DEPTH-1], "cell lost at pipeline tail")
  `ASSERT_NEXT(a_in_enters, in_valid && !in_stall, vld_r[0], "accepted cell not in pipeline")
  `ASSERT_NEXT(a_last_ends, out_valid && !out_stall && out_last_point && !mctl.load, !out_valid,
               "points shown after last point")
  `ASSERT_NOW(a_load_ok, mctl.load, vld_r[DEPTH-1] && adv, "merge load without a cell")
endmodule

FILE: rtl/core/iccec_lane.sv
`timescale 1ns / 1ps
// One edge: crossing test then a pipelined restoring divider, one quotient bit a stage.
module iccec_lane import iccec_pkg::*; (
  input  logic      clk,
  input  logic      adv,
  input  smp_t      a,
  input  smp_t      b,
  input  smp_t      lev,
  output lane_res_t res
);
  logic [SMP_W-1:0] rem_r [DEPTH];
  logic [SMP_W-1:0] den_r [DEPTH];
  logic [T_W-1:0]   q_r   [DEPTH];
  logic             cr_r  [DEPTH];

  logic             a_lo, b_lo;
  logic [SMP_W:0]   d_la, d_ba, d_al, d_ab;
  logic [SMP_W-1:0] num_nxt, den_nxt;

  always_comb begin
    a_lo = (a <= lev);
    b_lo = (b <= lev);
    d_la = {lev[SMP_W-1], lev} - {a[SMP_W-1], a};
    d_ba = {b[SMP_W-1], b} - {a[SMP_W-1], a};
    d_al = {a[SMP_W-1], a} - {lev[SMP_W-1], lev};
    d_ab = {a[SMP_W-1], a} - {b[SMP_W-1], b};
    if (a_lo) begin
      num_nxt = d_la[SMP_W-1:0];
      den_nxt = d_ba[SMP_W-1:0];
    end else begin
      num_nxt = d_al[SMP_W-1:0];
      den_nxt = d_ab[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= num_nxt;
      den_r[0] <= den_nxt;
      q_r[0]   <= '0;
      cr_r[0]  <= a_lo ^ b_lo;
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_stage
    logic [SMP_W:0] sh;
    logic [SMP_W:0] diff;
    logic           ge;
    // first stage takes the integer bit, no shift
    assign sh   = (k == 1) ? {1'b0, rem_r[k-1]} : {rem_r[k-1], 1'b0};
    assign ge   = (sh >= {1'b0, den_r[k-1]});
    assign diff = sh - {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? diff[SMP_W-1:0] : sh[SMP_W-1:0];
        den_r[k] <= den_r[k-1];
        q_r[k]   <= {q_r[k-1][T_W-2:0], ge};
        cr_r[k]  <= cr_r[k-1];
      end
    end
  end

  assign res.crossed = cr_r[DEPTH-1];
  assign res.t       = q_r[DEPTH-1];
endmodule

FILE: rtl/core/iccec_merge.sv
`timescale 1ns / 1ps
// Merges lane results into points and sends them out one a cycle unless out_stall holds them, lowest edge first.
module iccec_merge import iccec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tail_valid,
  input  lane_res_t  lres [NLANE],
  input  logic [CRD_W-1:0] col,
  input  logic [CRD_W-1:0] row,
  output mrg_ctl_t   ctl,
  output logic       out_valid,
  input  logic       out_stall,
  output pt_t        out_point_x,
  output pt_t        out_point_y,
  output edge_t      out_edge_id,
  output logic       out_last_point
);
  logic [NLANE-1:0] mask_r, mask_nxt, cur_oh, mask_left;
  pt_t              x_r [NLANE];
  pt_t              y_r [NLANE];
  edge_t            cur;
  logic             xfer;
  logic [PT_W:0]    cx, cy, one;
  logic [PT_W:0]    xv [NLANE];
  logic [PT_W:0]    yv [NLANE];

  always_comb begin
    cur = EDGE_LEFT;
    for (int i = NLANE - 1; i >= 0; i--) begin
      if (mask_r[i]) cur = edge_t'(i);
    end
    cur_oh    = mask_r & (~mask_r + 1'b1);
    xfer      = out_valid & ~out_stall;
    mask_left = xfer ? (mask_r & ~cur_oh) : mask_r;
    ctl.load_ok = (mask_left == '0);
    ctl.load    = tail_valid & ctl.load_ok;
    mask_nxt  = mask_left;
    if (ctl.load) begin
      for (int i = 0; i < NLANE; i++) mask_nxt[i] = lres[i].crossed;
    end
  end

  always_comb begin
    cx  = {1'b0, col, {FRAC_W{1'b0}}};
    cy  = {1'b0, row, {FRAC_W{1'b0}}};
    one = (PT_W + 1)'(1) << FRAC_W;
    xv[EDGE_BOTTOM] = cx + (PT_W + 1)'(lres[EDGE_BOTTOM].t);
    yv[EDGE_BOTTOM] = cy;
    xv[EDGE_RIGHT]  = cx + one;
    yv[EDGE_RIGHT]  = cy + (PT_W + 1)'(lres[EDGE_RIGHT].t);
    xv[EDGE_TOP]    = cx + one - (PT_W + 1)'(lres[EDGE_TOP].t);
    yv[EDGE_TOP]    = cy + one;
    xv[EDGE_LEFT]   = cx;
    yv[EDGE_LEFT]   = cy + one - (PT_W + 1)'(lres[EDGE_LEFT].t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < NLANE; i++) begin
        x_r[i] <= (xv[i] > XLIM) ? XLIM[PT_W-1:0] : xv[i][PT_W-1:0];
        y_r[i] <= (yv[i] > YLIM) ? YLIM[PT_W-1:0] : yv[i][PT_W-1:0];
      end
    end
  end

  assign out_valid      = (mask_r != '0);
  assign out_point_x    = x_r[cur];
  assign out_point_y    = y_r[cur];
  assign out_edge_id    = cur;
  assign out_last_point = ((mask_r & ~cur_oh) == '0);
endmodule

FILE: tb/crossing_checker.sv
`timescale 1ns / 1ps
module crossing_checker import iccec_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  smp_t             cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  smp_t             in_corner_low_left,
  input  smp_t             in_corner_low_right,
  input  smp_t             in_corner_up_right,
  input  smp_t             in_corner_up_left,
  input  logic [CRD_W-1:0] in_cell_column,
  input  logic [CRD_W-1:0] in_cell_row,
  input  logic             out_valid,
  input  logic             out_stall,
  input  pt_t              out_point_x,
  input  pt_t              out_point_y,
  input  edge_t            out_edge_id,
  input  logic             out_last_point,
  output int               mismatches,
  output int               points_pending,
  output int               points_seen
);

  typedef struct packed {
    pt_t   x;
    pt_t   y;
    edge_t side;
    logic  last;
  } crossing_t;

  crossing_t expected_points[$];
  smp_t      level;

  assign points_pending = expected_points.size();

  function automatic bit at_or_below(smp_t z, smp_t lev);
    return z <= lev;
  endfunction

  // truncated fraction from the start corner a towards b
  function automatic logic [31:0] frac_of(smp_t a, smp_t b, smp_t lev);
    logic [31:0] num;
    logic [31:0] den;
    if (a <= lev) begin
      num = 32'(int'(lev) - int'(a));
      den = 32'(int'(b) - int'(a));
    end else begin
      num = 32'(int'(a) - int'(lev));
      den = 32'(int'(a) - int'(b));
    end
    return (num << FRAC_W) / den;
  endfunction

  function automatic pt_t clamp_to(logic [31:0] v, logic [31:0] lim);
    return pt_t'(v > lim ? lim : v);
  endfunction

  task automatic predict_cell(smp_t z0, smp_t z1, smp_t z2, smp_t z3,
                              logic [CRD_W-1:0] col, logic [CRD_W-1:0] row);
    smp_t        z[4];
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] one;
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    crossing_t   pts[$];
    crossing_t   p;
    z[0] = z0; z[1] = z1; z[2] = z2; z[3] = z3;
    one = 32'd1 << FRAC_W;
    cx = 32'(col) << FRAC_W;
    cy = 32'(row) << FRAC_W;
    for (int e = 0; e < 4; e++) begin
      if (at_or_below(z[e], level) != at_or_below(z[(e + 1) % 4], level)) begin
        t = frac_of(z[e], z[(e + 1) % 4], level);
        case (edge_t'(e))
          EDGE_BOTTOM: begin x = cx + t;       y = cy;           end
          EDGE_RIGHT:  begin x = cx + one;     y = cy + t;       end
          EDGE_TOP:    begin x = cx + one - t; y = cy + one;     end
          default:     begin x = cx;           y = cy + one - t; end
        endcase
        p.x = clamp_to(x, 32'(XLIM));
        p.y = clamp_to(y, 32'(YLIM));
        p.side = edge_t'(e);
        p.last = 1'b0;
        pts = {pts, p};
      end
    end
    if (pts.size() > 0) pts[pts.size() - 1].last = 1'b1;
    foreach (pts[i]) expected_points = {expected_points, pts[i]};
  endtask

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    points_seen = 0;
  end

  always @(posedge clk) begin
    crossing_t want;
    if (!rst_n) begin
      level <= '0;
    end else begin
      if (cfg_wr_en) level <= cfg_wr_data;
      if (in_valid && !in_stall)
        predict_cell(in_corner_low_left, in_corner_low_right, in_corner_up_right,
                     in_corner_up_left, in_cell_column, in_cell_row);
      if (out_valid && !out_stall) begin
        points_seen++;
        if (expected_points.size() == 0) begin
          report_mismatch("point with none expected");
        end else begin
          want = expected_points.pop_front();
          if (out_point_x !== want.x)
            report_mismatch($sformatf("x %0d, want %0d", out_point_x, want.x));
          if (out_point_y !== want.y)
            report_mismatch($sformatf("y %0d, want %0d", out_point_y, want.y));
          if (out_edge_id !== want.side)
            report_mismatch($sformatf("edge %0d, want %0d", out_edge_id, want.side));
          if (out_last_point !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_last_point, want.last));
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the isoline edge-crossing block. The checker beside
// the block predicts every point; this module only drives cells, the level
// register and receiver back-pressure.
module tb;
  import iccec_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;   // pipeline is ~10 deep plus merge

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  smp_t             cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  smp_t             in_ll = '0, in_lr = '0, in_ur = '0, in_ul = '0;
  logic [CRD_W-1:0] in_col = '0, in_row = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  pt_t              out_x, out_y;
  edge_t            out_edge;
  logic             out_last;
  int               mismatches, points_pending, points_seen;
  int               cycles = 0;
  int               cells_sent = 0;
  bit               quiet_tail = 1'b0;   // no idling on either side
  bit               hold_rx = 1'b0;      // long receiver hold-off

  always #10 clk = ~clk;

  isoline_cell_edge_crossings dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_corner_low_left(in_ll), .in_corner_low_right(in_lr),
    .in_corner_up_right(in_ur), .in_corner_up_left(in_ul),
    .in_cell_column(in_col), .in_cell_row(in_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_x(out_x), .out_point_y(out_y),
    .out_edge_id(out_edge), .out_last_point(out_last)
  );

  crossing_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_corner_low_left(in_ll), .in_corner_low_right(in_lr),
    .in_corner_up_right(in_ur), .in_corner_up_left(in_ul),
    .in_cell_column(in_col), .in_cell_row(in_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_x(out_x), .out_point_y(out_y),
    .out_edge_id(out_edge), .out_last_point(out_last),
    .mismatches(mismatches), .points_pending(points_pending),
    .points_seen(points_seen)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall bursts, a forced hold-off, none in the tail
  initial begin
    int burst;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // hold-off counted in its own process, whilst the sender keeps offering;
  // placed in a sweep level where most cells have crossings
  initial begin
    wait (cells_sent == 200);
    hold_rx = 1'b1;
    repeat (150) @(posedge clk);
    hold_rx = 1'b0;
  end

  task automatic write_level(smp_t lev);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lev;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one cell transfer; payload held while stalled
  task automatic send_cell(smp_t ll, smp_t lr, smp_t ur, smp_t ul,
                           logic [CRD_W-1:0] col, logic [CRD_W-1:0] row);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ll <= ll; in_lr <= lr; in_ur <= ur; in_ul <= ul;
    in_col <= col; in_row <= row;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    cells_sent++;
  endtask

  task automatic idle_and_drain();
    in_valid <= 1'b0;
    wait (points_pending == 0);
    // cells with no crossing may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // samples near the level so that fractions and exact hits are common
  function automatic smp_t near_level(smp_t lev);
    int v;
    v = int'(lev) + $signed($urandom_range(0, 64)) - 32;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return smp_t'(v);
  endfunction

  function automatic smp_t any_sample();
    return smp_t'($urandom);
  endfunction

  task automatic random_cells(int count, smp_t lev);
    logic [CRD_W-1:0] col, row;
    for (int i = 0; i < count; i++) begin
      col = CRD_W'($urandom_range(0, 1023));
      row = CRD_W'($urandom_range(0, 1023));
      if ($urandom_range(0, 3) == 0)
        send_cell(any_sample(), any_sample(), any_sample(), any_sample(), col, row);
      else
        send_cell(near_level(lev), near_level(lev), near_level(lev),
                  near_level(lev), col, row);
    end
  endtask

  initial begin
    smp_t levels[5];
    levels[0] = 16'sh7fff;  // nothing can sit above this
    levels[1] = 16'sh8000;
    levels[2] = 16'sd1234;
    levels[3] = -16'sd500;
    levels[4] = 16'sd0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed, level 0 from reset
    send_cell(-16'sd1, 16'sd1, 16'sd1, -16'sd1, 10'd0, 10'd0);           // bottom/top
    send_cell(-16'sd10, 16'sd0, 16'sd10, 16'sd0, 10'd5, 10'd7);         // t at one
    send_cell(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 10'd1023, 10'd1023); // saddle, clamp
    send_cell(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 10'd1022, 10'd1022);
    send_cell(16'sd5, 16'sd6, 16'sd7, 16'sd8, 10'd3, 10'd3);             // no crossing
    send_cell(-16'sd5, -16'sd6, -16'sd7, -16'sd8, 10'd3, 10'd3);         // all below
    send_cell(16'sd0, 16'sd0, 16'sd1, 16'sd0, 10'h2aa, 10'h155);         // level hit
    send_cell(16'sd1, -16'sd3, -16'sd3, -16'sd3, 10'h155, 10'h2aa);
    send_cell(-16'sd3, 16'sd1, -16'sd3, -16'sd3, 10'd0, 10'd1023);
    send_cell(-16'sd3, -16'sd3, 16'sd1, -16'sd3, 10'd1023, 10'd0);
    send_cell(-16'sd3, -16'sd3, -16'sd3, 16'sd1, 10'd512, 10'd511);
    send_cell(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 10'd100, 10'd200);
    idle_and_drain();

    // level sweep with extremes; most cells have samples near the level
    foreach (levels[k]) begin
      write_level(levels[k]);
      if (k == 4) quiet_tail = 1'b1;
      random_cells(80, levels[k]);
      idle_and_drain();
    end

    $display("covered %0d cells and %0d points over five levels incl. both extremes",
             cells_sent, points_seen);
    $display("with random idling both sides and a long output hold-off");
    if (mismatches == 0 && points_pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: isoline_cell_edge_crossings.f
+incdir+rtl/core
rtl/core/iccec_pkg.sv
rtl/core/iccec_lane.sv
rtl/core/iccec_merge.sv
rtl/core/isoline_cell_edge_crossings.sv
tb/crossing_checker.sv
tb/tb.sv
